FILE: hdl/nnps_pkg.sv
package nnps_pkg;

    // Pixel word as it travels on the streams: red in the low byte, then green, then blue.
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    // Width of the factor, the divisor and the per-item result count.
    localparam int CNT_W      = 7;
    // The remainder of the output width division stays below the divisor (at most 64).
    localparam int REM_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHRINK_MODE    = 2'd0,
        REG_ENLARGE_FACTOR = 2'd1,
        REG_SHRINK_DIVISOR = 2'd2,
        REG_INPUT_WIDTH    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    // Settings and derived values that the front end needs.
    typedef struct packed {
        logic             busy;
        logic             shrink;
        logic [CNT_W-1:0] factor;
        logic [CNT_W-1:0] divisor;
        logic             ow_zero;
        logic [1:0]       pad_enl;
        logic [1:0]       pad_shr;
    } cfg_ctl_t;

    // One classified job: a pixel to be emitted count times.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] count;
        logic             row_end;
        logic [1:0]       pad;
        logic             replaying;
    } entry_t;

endpackage

FILE: hdl/nnps_cfg.sv
module nnps_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 64,
    parameter int WW         = 11
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nnps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nnps_pkg::CFG_DATA_W-1:0]      cfg_data,
    output nnps_pkg::cfg_ctl_t                   ctl,
    output logic [WW-1:0]                        width,
    output logic [WW-1:0]                        owd,
    output logic [WW-1:0]                        lstart
);

    localparam int SW = $clog2(WW + 1);

    logic                           shrink_reg, shrink_next;
    logic [nnps_pkg::CNT_W-1:0]     f_reg, f_next;
    logic [nnps_pkg::CNT_W-1:0]     d_reg, d_next;
    logic [WW-1:0]                  w_reg, w_next;
    logic                           busy_reg, busy_next;
    logic [SW-1:0]                  step_reg, step_next;
    logic [nnps_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [WW-1:0]                  quo_reg, quo_next;
    logic [nnps_pkg::CNT_W-1:0]     rem_sh;
    logic [nnps_pkg::CNT_W-1:0]     trial;
    logic [3:0]                     pad_prod;

    function automatic logic [nnps_pkg::CNT_W-1:0] clamp_factor(
        input logic [nnps_pkg::CNT_W-1:0] v
    );
        logic [nnps_pkg::CNT_W-1:0] r;
        if (v == '0) begin
            r = nnps_pkg::CNT_W'(1);
        end else if (32'(v) > MAX_FACTOR) begin
            r = nnps_pkg::CNT_W'(MAX_FACTOR);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [WW-1:0] clamp_width(
        input logic [nnps_pkg::CFG_DATA_W-1:0] v
    );
        logic [WW-1:0] r;
        if (v == '0) begin
            r = WW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WW'(MAX_WIDTH);
        end else begin
            r = WW'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // Restoring division of the width by the divisor, one quotient bit a cycle.
    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign rem_sh = {rem_reg, quo_reg[WW-1]};
    assign trial  = rem_sh - d_reg;

    always_comb begin
        shrink_next = shrink_reg;
        f_next      = f_reg;
        d_next      = d_reg;
        w_next      = w_reg;
        busy_next   = busy_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (busy_reg) begin
            if (rem_sh >= d_reg) begin
                rem_next = trial[nnps_pkg::REM_W-1:0];
                quo_next = {quo_reg[WW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[nnps_pkg::REM_W-1:0];
                quo_next = {quo_reg[WW-2:0], 1'b0};
            end
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1)) begin
                busy_next = 1'b0;
            end
        end
        if (cfg_valid) begin
            unique case (nnps_pkg::cfg_reg_t'(cfg_index))
                nnps_pkg::REG_SHRINK_MODE: begin
                    shrink_next = cfg_data[0];
                end
                nnps_pkg::REG_ENLARGE_FACTOR: begin
                    f_next = clamp_factor(cfg_data[nnps_pkg::CNT_W-1:0]);
                end
                nnps_pkg::REG_SHRINK_DIVISOR: begin
                    d_next = clamp_factor(cfg_data[nnps_pkg::CNT_W-1:0]);
                end
                nnps_pkg::REG_INPUT_WIDTH: begin
                    w_next = clamp_width(cfg_data);
                end
            endcase
            // Any write restarts the division with the new width.
            busy_next = 1'b1;
            step_next = SW'(WW);
            rem_next  = '0;
            quo_next  = w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shrink_reg <= 1'b0;
            f_reg      <= nnps_pkg::CNT_W'(1);
            d_reg      <= nnps_pkg::CNT_W'(1);
            w_reg      <= WW'(1);
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            rem_reg    <= '0;
            quo_reg    <= WW'(1);
        end else begin
            shrink_reg <= shrink_next;
            f_reg      <= f_next;
            d_reg      <= d_next;
            w_reg      <= w_next;
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
        end
    end

    // Row padding is the output width modulo four.
    assign pad_prod = {2'b00, w_reg[1:0]} * {2'b00, f_reg[1:0]};

    assign ctl.busy    = busy_reg;
    assign ctl.shrink  = shrink_reg;
    assign ctl.factor  = f_reg;
    assign ctl.divisor = d_reg;
    assign ctl.ow_zero = (32'(w_reg) < 32'(d_reg));
    assign ctl.pad_enl = pad_prod[1:0];
    assign ctl.pad_shr = quo_reg[1:0];

    assign width  = w_reg;
    assign owd    = w_reg - WW'(rem_reg);
    assign lstart = owd - WW'(d_reg);

endmodule

FILE: hdl/nnps_front.sv
module nnps_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 64,
    parameter int AW         = 10,
    parameter int PW         = 6,
    parameter int WW         = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nnps_pkg::PIX_W-1:0]    s_tdata,
    input  logic [0:0]                    s_tuser,
    input  nnps_pkg::cfg_ctl_t            ctl,
    input  logic [WW-1:0]                 width,
    input  logic [WW-1:0]                 owd,
    input  logic [WW-1:0]                 lstart,
    output logic                          push,
    output nnps_pkg::entry_t              push_entry,
    input  logic                          fifo_full
);

    logic [nnps_pkg::PIX_W-1:0]  store_mem [MAX_WIDTH];

    logic [AW-1:0]               cc_reg, cc_next;
    logic [PW-1:0]               cph_reg, cph_next;
    logic [PW-1:0]               rph_reg, rph_next;
    logic [PW-1:0]               rtr_reg, rtr_next;
    logic [AW-1:0]               rc_reg, rc_next;
    logic                        cmd_valid_reg;
    nnps_pkg::entry_t            cmd_reg;
    logic                        use_store_reg;
    logic [nnps_pkg::PIX_W-1:0]  rd_data_reg;

    logic                        accept;
    logic                        adv;
    logic                        cc_end;
    logic                        rc_end;
    logic                        keep;
    logic [nnps_pkg::CNT_W-1:0]  cph_inc;
    logic [nnps_pkg::CNT_W-1:0]  rph_inc;
    nnps_pkg::entry_t            ent;
    logic                        has_res;
    logic                        use_store;
    logic                        wr_en;
    logic                        rd_en;

    assign adv      = !cmd_valid_reg || !fifo_full;
    assign s_tready = adv && !ctl.busy;
    assign accept   = s_tvalid && s_tready;
    assign push     = cmd_valid_reg && !fifo_full;

    assign cc_end  = (32'(cc_reg) + 32'd1 >= 32'(width));
    assign rc_end  = (32'(rc_reg) + 32'd1 >= 32'(width));
    assign cph_inc = nnps_pkg::CNT_W'(cph_reg) + nnps_pkg::CNT_W'(1);
    assign rph_inc = nnps_pkg::CNT_W'(rph_reg) + nnps_pkg::CNT_W'(1);
    assign keep    = !ctl.ow_zero && (cph_reg == '0) && (rph_reg == '0)
                     && (32'(cc_reg) < 32'(owd));

    always_comb begin
        cc_next   = cc_reg;
        cph_next  = cph_reg;
        rph_next  = rph_reg;
        rtr_next  = rtr_reg;
        rc_next   = rc_reg;
        ent       = '0;
        has_res   = 1'b0;
        use_store = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        if (accept) begin
            if (nnps_pkg::opcode_t'(s_tuser[0]) == nnps_pkg::OP_TICK) begin
                if (rtr_reg != '0) begin
                    has_res   = 1'b1;
                    use_store = 1'b1;
                    rd_en     = 1'b1;
                    ent.count = nnps_pkg::CNT_W'(1);
                    ent.pad   = ctl.pad_enl;
                    if (cph_inc >= ctl.factor) begin
                        cph_next = '0;
                        if (rc_end) begin
                            ent.row_end = 1'b1;
                            rc_next     = '0;
                            rtr_next    = rtr_reg - PW'(1);
                        end else begin
                            rc_next = rc_reg + AW'(1);
                        end
                    end else begin
                        cph_next = cph_inc[PW-1:0];
                    end
                end
            end else if (!ctl.shrink) begin
                // While replayed rows are pending a new pixel is dropped.
                if (rtr_reg == '0) begin
                    has_res     = 1'b1;
                    wr_en       = 1'b1;
                    ent.pix     = s_tdata;
                    ent.count   = ctl.factor;
                    ent.row_end = cc_end;
                    ent.pad     = ctl.pad_enl;
                    if (cc_end) begin
                        cc_next  = '0;
                        rtr_next = PW'(ctl.factor - nnps_pkg::CNT_W'(1));
                        rc_next  = '0;
                        cph_next = '0;
                    end else begin
                        cc_next = cc_reg + AW'(1);
                    end
                end
            end else begin
                if (keep) begin
                    has_res     = 1'b1;
                    ent.pix     = s_tdata;
                    ent.count   = nnps_pkg::CNT_W'(1);
                    ent.row_end = (32'(cc_reg) == 32'(lstart));
                    ent.pad     = ctl.pad_shr;
                end
                if (cc_end) begin
                    cc_next  = '0;
                    cph_next = '0;
                    rph_next = (rph_inc >= ctl.divisor) ? '0 : rph_inc[PW-1:0];
                end else begin
                    cc_next  = cc_reg + AW'(1);
                    cph_next = (cph_inc >= ctl.divisor) ? '0 : cph_inc[PW-1:0];
                end
            end
            ent.replaying = (rtr_next != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg        <= '0;
            cph_reg       <= '0;
            rph_reg       <= '0;
            rtr_reg       <= '0;
            rc_reg        <= '0;
            cmd_valid_reg <= 1'b0;
        end else begin
            cc_reg  <= cc_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
            rtr_reg <= rtr_next;
            rc_reg  <= rc_next;
            if (accept) begin
                cmd_valid_reg <= has_res;
            end else if (push) begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= ent;
            use_store_reg <= use_store;
        end
    end

    // Line store: at most one write or one read per accepted item, read data registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[cc_reg] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rc_reg];
        end
    end

    always_comb begin
        push_entry = cmd_reg;
        if (use_store_reg) begin
            push_entry.pix = rd_data_reg;
        end
    end

endmodule

FILE: hdl/nnps_fifo.sv
module nnps_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nnps_pkg::entry_t  push_entry,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output nnps_pkg::entry_t  head
);

    nnps_pkg::entry_t                 q_mem [nnps_pkg::FIFO_DEPTH];
    logic [nnps_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [nnps_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [nnps_pkg::FIFO_AW:0]       count_reg;

    assign full  = (32'(count_reg) == nnps_pkg::FIFO_DEPTH);
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + nnps_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + nnps_pkg::FIFO_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (nnps_pkg::FIFO_AW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (nnps_pkg::FIFO_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (32'(count_reg) != nnps_pkg::FIFO_DEPTH))
        else $error("job queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("job queue read while empty");
`endif

endmodule

FILE: hdl/nnps_back.sv
module nnps_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nnps_pkg::entry_t              head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nnps_pkg::PIX_W-1:0]    m_tdata,
    output logic [3:0]                    m_tuser,
    output logic                          m_tlast
);

    logic [nnps_pkg::CNT_W-1:0]  k_reg, k_next;
    logic                        m_valid_reg, m_valid_next;
    logic [nnps_pkg::PIX_W-1:0]  tdata_reg;
    logic [3:0]                  tuser_reg;
    logic                        tlast_reg;

    logic                        out_free;
    logic                        emit;
    logic                        last_res;
    logic                        row_end;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = !empty && out_free;
    assign last_res = ((k_reg + nnps_pkg::CNT_W'(1)) == head.count);
    assign pop      = emit && last_res;
    assign row_end  = head.row_end && last_res;

    always_comb begin
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            k_next       = last_res ? '0 : k_reg + nnps_pkg::CNT_W'(1);
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            tdata_reg <= head.pix;
            tuser_reg <= {head.replaying, (row_end ? head.pad : 2'b00), row_end};
            tlast_reg <= last_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

`ifndef SYNTHESIS
    a_count_idle_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (k_reg == '0))
        else $error("repeat count left running with no job queued");

    a_count_below_job: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (k_reg < head.count))
        else $error("repeat count ran past the job length");

    a_count_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (k_reg == '0))
        else $error("repeat count not cleared after a job finished");
`endif

endmodule

FILE: hdl/nearest_neighbor_pixel_scaler.sv
// Throughput: one input item per clock while no division runs and the job queue has room;
//   results leave at one per clock while taken, so an enlarge pixel holds the input side
//   during its repeats once the job queue has filled. The first result of an item reaches
//   the master side through the classify stage, the job queue and the output register.
// A register write stalls the input while the divider runs over the width bits (11 by default).
// Reset (aresetn low, synchronous) clears counters and settings; the line store is not cleared.

// Nearest-neighbor scaler for a raster stream of 24-bit RGB pixels.
//
// The design has a decoupled front and back end. The configuration block holds the settings
// (already clamped to their legal ranges) and runs a bit-serial divider that works out the
// shrink-mode output width. The front end accepts one item per clock unless a division runs or
// the job queue is full, keeps the row and column bookkeeping, owns the line store and turns
// every item into at most one job: a pixel and how many times to send it. A four-entry job
// queue sits between the two halves so the front end keeps taking items while results wait.
// The back end plays each job out, one result per clock while taken, into an output register.
//
// In enlarge mode a pixel goes out enlarge_factor times and is written to the line store. At
// row end the stored row must be sent enlarge_factor-1 more times, each at the same horizontal
// scale; every tick item sends one result of a replayed row. Pixels that arrive while replayed
// rows are still pending are dropped. In shrink mode a pixel is kept only on columns and rows
// that are multiples of the divisor and inside the output width.
//
// The last pixel of every output row carries the number of zero bytes that pad the row to a
// multiple of four bytes.
module nearest_neighbor_pixel_scaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [nnps_pkg::PIX_W-1:0]          s_tdata,
    // [0] opcode (0 pixel, 1 tick)
    input  logic [0:0]                          s_tuser,

    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [nnps_pkg::PIX_W-1:0]          m_tdata,
    // [0] row_end, [2:1] pad_bytes, [3] replaying
    output logic [3:0]                          m_tuser,
    // Final result caused by the input item.
    output logic                                m_tlast,

    // Register writes: 0 shrink_mode, 1 enlarge_factor, 2 shrink_divisor, 3 input_width.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nnps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Column counters and line store address.
    localparam int AW = $clog2(MAX_WIDTH);
    // Phase counters and pending row count stay below the largest factor.
    localparam int PW = $clog2(MAX_FACTOR);
    // Clamped row width.
    localparam int WW = $clog2(MAX_WIDTH + 1);

    nnps_pkg::cfg_ctl_t  ctl;
    logic [WW-1:0]       width;
    logic [WW-1:0]       owd;
    logic [WW-1:0]       lstart;
    logic                push;
    nnps_pkg::entry_t    push_entry;
    logic                fifo_full;
    logic                fifo_empty;
    logic                pop;
    nnps_pkg::entry_t    head;

    // Settings and output width divider.
    nnps_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .WW         (WW)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .width     (width),
        .owd       (owd),
        .lstart    (lstart)
    );

    // Item intake, classification and line store.
    nnps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .AW         (AW),
        .PW         (PW),
        .WW         (WW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .ctl        (ctl),
        .width      (width),
        .owd        (owd),
        .lstart     (lstart),
        .push       (push),
        .push_entry (push_entry),
        .fifo_full  (fifo_full)
    );

    // Job queue between the two halves.
    nnps_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .empty      (fifo_empty),
        .pop        (pop),
        .head       (head)
    );

    // Result generation.
    nnps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
